// File: sv/lbc_pkg.sv
// ----------------------------------------------------------------------------
// Liang-Barsky clipper package
// Widths, stage numbering, register indexes, pipeline record types and the
// restoring divider step shared by the clipper modules.
// ----------------------------------------------------------------------------
package lbc_pkg;

   localparam int COORD_BITS = 10;
   localparam int SW         = COORD_BITS + 1;       // signed difference width
   localparam int PW         = 2 * SW;               // signed product width
   localparam int SUMW       = PW + 2;               // rounding numerator, signed
   localparam int TW         = 2 * COORD_BITS + 1;   // rounding numerator, visible
   localparam int LANES      = 4;
   localparam int EDGES      = 4;

   // Pipeline stage numbering.
   localparam int ST_PREP  = 0;
   localparam int ST_EDGE0 = 1;
   localparam int ST_FINAL = ST_EDGE0 + EDGES;
   localparam int ST_SUM   = ST_FINAL + 1;
   localparam int ST_DIV0  = ST_SUM + 1;
   localparam int ST_OUT   = ST_DIV0 + COORD_BITS;
   localparam int NSTAGE   = ST_OUT + 1;

   // Register indexes.
   localparam logic [1:0] REG_CORNER_A_X = 2'd0;
   localparam logic [1:0] REG_CORNER_A_Y = 2'd1;
   localparam logic [1:0] REG_CORNER_B_X = 2'd2;
   localparam logic [1:0] REG_CORNER_B_Y = 2'd3;

   // Divider lanes.
   localparam int LANE_EXIT_X  = 0;
   localparam int LANE_EXIT_Y  = 1;
   localparam int LANE_ENTRY_X = 2;
   localparam int LANE_ENTRY_Y = 3;

   typedef struct packed {
      logic [COORD_BITS-1:0]       x1;
      logic [COORD_BITS-1:0]       y1;
      logic [SW-1:0]               dx;
      logic [SW-1:0]               dy;
      logic [EDGES-1:0][SW-1:0]    p;
      logic [EDGES-1:0][SW-1:0]    q;
      logic                        reject;
      logic [SW-1:0]               lo_n;
      logic [COORD_BITS-1:0]       lo_d;
      logic [SW-1:0]               hi_n;
      logic [COORD_BITS-1:0]       hi_d;
   } clip_type;

   typedef struct packed {
      logic                                  reject;
      logic [LANES-1:0][2*COORD_BITS-1:0]    base_prod;
      logic [LANES-1:0][PW-1:0]              num_prod;
      logic [LANES-1:0][COORD_BITS-1:0]      den;
   } fin_type;

   typedef struct packed {
      logic [COORD_BITS:0]   rem;
      logic [COORD_BITS-1:0] low;
      logic [COORD_BITS-1:0] quo;
   } lane_type;

   typedef struct packed {
      logic                              reject;
      logic [LANES-1:0][COORD_BITS:0]    bot;
      lane_type [LANES-1:0]              lane;
   } div_type;

   // One restoring division step: bring down the next dividend bit.
   function automatic lane_type div_step(lane_type cur, logic [COORD_BITS:0] bot);
      logic [COORD_BITS+1:0] t;
      lane_type              nxt;
      t       = {cur.rem, cur.low[COORD_BITS-1]};
      nxt.low = {cur.low[COORD_BITS-2:0], 1'b0};
      if (t >= {1'b0, bot}) begin
         nxt.rem = (COORD_BITS+1)'(t - {1'b0, bot});
         nxt.quo = {cur.quo[COORD_BITS-2:0], 1'b1};
      end else begin
         nxt.rem = t[COORD_BITS:0];
         nxt.quo = {cur.quo[COORD_BITS-2:0], 1'b0};
      end
      return nxt;
   endfunction

endpackage

// File: sv/lbc_edge_stage.sv
// ----------------------------------------------------------------------------
// Liang-Barsky edge stage
// Applies one window edge to the entry and exit fractions and registers the
// updated record.
// ----------------------------------------------------------------------------
module lbc_edge_stage (
   input  logic             clock,
   input  logic             en,
   input  logic [1:0]       edge_idx,
   input  lbc_pkg::clip_type edge_in,
   output lbc_pkg::clip_type state_ff
);
   import lbc_pkg::*;

   logic signed [SW-1:0]  pv;
   logic signed [SW-1:0]  qv;
   logic signed [SW-1:0]  n;
   logic [COORD_BITS-1:0] d;
   logic signed [PW-1:0]  n_hi;
   logic signed [PW-1:0]  hi_d_cross;
   logic signed [PW-1:0]  n_lo;
   logic signed [PW-1:0]  lo_d_cross;
   clip_type              state_in;

   always_comb begin
      pv = $signed(edge_in.p[edge_idx]);
      qv = $signed(edge_in.q[edge_idx]);
      n  = (pv < 0) ? -qv : qv;
      d  = COORD_BITS'((pv < 0) ? -pv : pv);
      n_hi       = n * $signed({1'b0, edge_in.hi_d});
      hi_d_cross = $signed(edge_in.hi_n) * $signed({1'b0, d});
      n_lo       = n * $signed({1'b0, edge_in.lo_d});
      lo_d_cross = $signed(edge_in.lo_n) * $signed({1'b0, d});

      state_in = edge_in;
      if (!edge_in.reject) begin
         if (pv < 0) begin
            // Entering edge: ratio above the exit fraction rejects.
            if (n_hi > hi_d_cross) begin
               state_in.reject = 1'b1;
            end else if (n_lo > lo_d_cross) begin
               state_in.lo_n = n;
               state_in.lo_d = d;
            end
         end else if (pv > 0) begin
            if (n_lo < lo_d_cross) begin
               state_in.reject = 1'b1;
            end else if (n_hi < hi_d_cross) begin
               state_in.hi_n = n;
               state_in.hi_d = d;
            end
         end else if (qv < 0) begin
            // Parallel to the edge and wholly outside it.
            state_in.reject = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         state_ff <= state_in;
      end
   end

endmodule

// File: sv/liang_barsky_line_clipper_unit.sv
// ----------------------------------------------------------------------------
// Liang-Barsky line clipper
// Clips one segment per beat against a window set by two corner registers.
// ----------------------------------------------------------------------------
// The unit accepts one segment per clock while the result side is not stalled
// and returns one result per segment in order. A segment passes through the
// pipeline: one stage forms the edge terms, four stages apply one window edge
// each, one stage makes the final test and forms the rounding products and one
// their sums, then a restoring divider retires one quotient bit per stage
// before the output register.
// Each stage advances on its own, so bubbles close up while the output waits.
module liang_barsky_line_clipper_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [lbc_pkg::COORD_BITS-1:0]   req_start_x,
   input  logic [lbc_pkg::COORD_BITS-1:0]   req_start_y,
   input  logic [lbc_pkg::COORD_BITS-1:0]   req_end_x,
   input  logic [lbc_pkg::COORD_BITS-1:0]   req_end_y,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_visible,
   output logic [lbc_pkg::COORD_BITS-1:0]   rsp_exit_x,
   output logic [lbc_pkg::COORD_BITS-1:0]   rsp_exit_y,
   output logic [lbc_pkg::COORD_BITS-1:0]   rsp_entry_x,
   output logic [lbc_pkg::COORD_BITS-1:0]   rsp_entry_y,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [3:0]                       paddr,
   input  logic [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);
   import lbc_pkg::*;

   logic [COORD_BITS-1:0] corner_a_x_ff;
   logic [COORD_BITS-1:0] corner_a_y_ff;
   logic [COORD_BITS-1:0] corner_b_x_ff;
   logic [COORD_BITS-1:0] corner_b_y_ff;
   logic [COORD_BITS-1:0] rd_value;

   logic [NSTAGE-1:0]     valid_ff;
   logic [NSTAGE-1:0]     valid_in;
   logic [NSTAGE:0]       en;

   clip_type              prep_in;
   clip_type              prep_ff;
   clip_type              edge_q [EDGES];
   fin_type               fin_in;
   fin_type               fin_ff;
   div_type               sum_in;
   div_type               div_ff [COORD_BITS+1];

   logic                  visible_ff;
   logic [COORD_BITS-1:0] exit_x_ff;
   logic [COORD_BITS-1:0] exit_y_ff;
   logic [COORD_BITS-1:0] entry_x_ff;
   logic [COORD_BITS-1:0] entry_y_ff;

   logic [COORD_BITS-1:0] xmin;
   logic [COORD_BITS-1:0] xmax;
   logic [COORD_BITS-1:0] ymin;
   logic [COORD_BITS-1:0] ymax;
   logic [SW-1:0]         dx;
   logic [SW-1:0]         dy;

   // ---------------------------------------------------------------- registers
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         corner_a_x_ff <= '0;
         corner_a_y_ff <= '0;
         corner_b_x_ff <= '1;
         corner_b_y_ff <= '1;
      end else if (psel && penable && pwrite && pready) begin
         case (paddr[3:2])
            REG_CORNER_A_X: corner_a_x_ff <= pwdata[COORD_BITS-1:0];
            REG_CORNER_A_Y: corner_a_y_ff <= pwdata[COORD_BITS-1:0];
            REG_CORNER_B_X: corner_b_x_ff <= pwdata[COORD_BITS-1:0];
            REG_CORNER_B_Y: corner_b_y_ff <= pwdata[COORD_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_CORNER_A_X: rd_value = corner_a_x_ff;
         REG_CORNER_A_Y: rd_value = corner_a_y_ff;
         REG_CORNER_B_X: rd_value = corner_b_x_ff;
         REG_CORNER_B_Y: rd_value = corner_b_y_ff;
         default:        rd_value = '0;
      endcase
   end
   assign prdata = 32'(rd_value);

   // ------------------------------------------------------------ flow control
   // A stage moves on when it is empty or the stage after it moves on.
   assign en[NSTAGE] = rsp_ready;
   genvar k;
   generate
      for (k = 0; k < NSTAGE; k++) begin : g_en
         assign en[k] = !valid_ff[k] || en[k+1];
      end
   endgenerate

   assign valid_in  = {valid_ff[NSTAGE-2:0], req_valid};
   assign req_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < NSTAGE; i++) begin
            if (en[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   // ---------------------------------------------------------- edge terms
   always_comb begin
      xmin = (corner_a_x_ff < corner_b_x_ff) ? corner_a_x_ff : corner_b_x_ff;
      xmax = (corner_a_x_ff < corner_b_x_ff) ? corner_b_x_ff : corner_a_x_ff;
      ymin = (corner_a_y_ff < corner_b_y_ff) ? corner_a_y_ff : corner_b_y_ff;
      ymax = (corner_a_y_ff < corner_b_y_ff) ? corner_b_y_ff : corner_a_y_ff;
      dx   = SW'(req_end_x) - SW'(req_start_x);
      dy   = SW'(req_end_y) - SW'(req_start_y);

      prep_in.x1     = req_start_x;
      prep_in.y1     = req_start_y;
      prep_in.dx     = dx;
      prep_in.dy     = dy;
      prep_in.p[0]   = -dx;
      prep_in.q[0]   = SW'(req_start_x) - SW'(xmin);
      prep_in.p[1]   = dx;
      prep_in.q[1]   = SW'(xmax) - SW'(req_start_x);
      prep_in.p[2]   = -dy;
      prep_in.q[2]   = SW'(req_start_y) - SW'(ymin);
      prep_in.p[3]   = dy;
      prep_in.q[3]   = SW'(ymax) - SW'(req_start_y);
      prep_in.reject = 1'b0;
      prep_in.lo_n   = '0;
      prep_in.lo_d   = COORD_BITS'(1);
      prep_in.hi_n   = SW'(1);
      prep_in.hi_d   = COORD_BITS'(1);
   end

   always_ff @(posedge clock) begin
      if (en[ST_PREP]) begin
         prep_ff <= prep_in;
      end
   end

   // ---------------------------------------------------------- window edges
   generate
      for (k = 0; k < EDGES; k++) begin : g_edge
         lbc_edge_stage u_edge (
            .clock    (clock),
            .en       (en[ST_EDGE0+k]),
            .edge_idx (2'(k)),
            .edge_in  ((k == 0) ? prep_ff : edge_q[(k == 0) ? 0 : k-1]),
            .state_ff (edge_q[k])
         );
      end
   endgenerate

   // ------------------------------------------- final test, rounding products
   always_comb begin
      clip_type             c;
      logic signed [PW-1:0] lo_cross;
      logic signed [PW-1:0] hi_cross;
      c = edge_q[EDGES-1];
      lo_cross = $signed(c.lo_n) * $signed({1'b0, c.hi_d});
      hi_cross = $signed(c.hi_n) * $signed({1'b0, c.lo_d});
      fin_in.reject = c.reject || (lo_cross > hi_cross);
      fin_in.base_prod[LANE_EXIT_X]  = (2*COORD_BITS)'(c.x1 * c.hi_d);
      fin_in.base_prod[LANE_EXIT_Y]  = (2*COORD_BITS)'(c.y1 * c.hi_d);
      fin_in.base_prod[LANE_ENTRY_X] = (2*COORD_BITS)'(c.x1 * c.lo_d);
      fin_in.base_prod[LANE_ENTRY_Y] = (2*COORD_BITS)'(c.y1 * c.lo_d);
      fin_in.num_prod[LANE_EXIT_X]   = PW'($signed(c.hi_n) * $signed(c.dx));
      fin_in.num_prod[LANE_EXIT_Y]   = PW'($signed(c.hi_n) * $signed(c.dy));
      fin_in.num_prod[LANE_ENTRY_X]  = PW'($signed(c.lo_n) * $signed(c.dx));
      fin_in.num_prod[LANE_ENTRY_Y]  = PW'($signed(c.lo_n) * $signed(c.dy));
      fin_in.den[LANE_EXIT_X]        = c.hi_d;
      fin_in.den[LANE_EXIT_Y]        = c.hi_d;
      fin_in.den[LANE_ENTRY_X]       = c.lo_d;
      fin_in.den[LANE_ENTRY_Y]       = c.lo_d;
   end

   always_ff @(posedge clock) begin
      if (en[ST_FINAL]) begin
         fin_ff <= fin_in;
      end
   end

   // ------------------------------------------------- rounding numerators
   // Round half up: floor((2*(base*den + num*delta) + den) / (2*den)).
   always_comb begin
      logic signed [SUMW-1:0] top;
      sum_in.reject = fin_ff.reject;
      for (int i = 0; i < LANES; i++) begin
         top = (($signed(SUMW'(fin_ff.base_prod[i])) +
                 SUMW'($signed(fin_ff.num_prod[i]))) <<< 1) +
               $signed(SUMW'(fin_ff.den[i]));
         sum_in.bot[i]      = {fin_ff.den[i], 1'b0};
         sum_in.lane[i].rem = top[TW-1:COORD_BITS];
         sum_in.lane[i].low = top[COORD_BITS-1:0];
         sum_in.lane[i].quo = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_SUM]) begin
         div_ff[0] <= sum_in;
      end
   end

   // ------------------------------------------------------------- divider
   generate
      for (k = 0; k < COORD_BITS; k++) begin : g_div
         div_type step_in;
         always_comb begin
            step_in = div_ff[k];
            for (int i = 0; i < LANES; i++) begin
               step_in.lane[i] = div_step(div_ff[k].lane[i], div_ff[k].bot[i]);
            end
         end
         always_ff @(posedge clock) begin
            if (en[ST_DIV0+k]) begin
               div_ff[k+1] <= step_in;
            end
         end
      end
   endgenerate

   // -------------------------------------------------------------- output
   always_ff @(posedge clock) begin
      if (en[ST_OUT]) begin
         visible_ff <= !div_ff[COORD_BITS].reject;
         if (div_ff[COORD_BITS].reject) begin
            exit_x_ff  <= '0;
            exit_y_ff  <= '0;
            entry_x_ff <= '0;
            entry_y_ff <= '0;
         end else begin
            exit_x_ff  <= div_ff[COORD_BITS].lane[LANE_EXIT_X].quo;
            exit_y_ff  <= div_ff[COORD_BITS].lane[LANE_EXIT_Y].quo;
            entry_x_ff <= div_ff[COORD_BITS].lane[LANE_ENTRY_X].quo;
            entry_y_ff <= div_ff[COORD_BITS].lane[LANE_ENTRY_Y].quo;
         end
      end
   end

   assign rsp_valid   = valid_ff[ST_OUT];
   assign rsp_visible = visible_ff;
   assign rsp_exit_x  = exit_x_ff;
   assign rsp_exit_y  = exit_y_ff;
   assign rsp_entry_x = entry_x_ff;
   assign rsp_entry_y = entry_y_ff;

   // ---------------------------------------------------------- assertions
   // A stalled stage never drops its beat.
   assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (($past(valid_ff) & ~$past(en[NSTAGE-1:0]) & ~valid_ff) == '0))
      else $error("pipeline stage lost a beat while stalled");

   // Input is refused only when every stage holds a beat.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (&valid_ff))
      else $error("input refused with a bubble in the pipeline");

   // A surviving entry fraction is not negative.
   assert property (@(posedge clock) disable iff (reset)
      (valid_ff[ST_FINAL-1] && !edge_q[EDGES-1].reject) |->
      ($signed(edge_q[EDGES-1].lo_n) >= 0))
      else $error("entry fraction negative on a visible segment");

   // A rejected segment reports all coordinates as zero.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_visible) |->
      (rsp_exit_x == '0 && rsp_exit_y == '0 && rsp_entry_x == '0 && rsp_entry_y == '0))
      else $error("rejected segment carries non-zero coordinates");

endmodule
